FILE: design/dss_pkg.sv
// ----------------------------------------------------------------------------
// Dual stack shared array package
// Sizes, result codes and operation codes shared by the block's files.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_DUMP = 2'd2;

	localparam logic END_HIGH = 1'b0;
	localparam logic END_LOW  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2,
		ST_FREE  = 2'd3
	} status_t;

endpackage

FILE: design/dss_if.sv
// ----------------------------------------------------------------------------
// Dual stack shared array channels
// Command item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dss_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic               end_select;
	logic signed [31:0] value;

	modport source (output valid, output operation, output end_select, output value,
		input ready);
	modport sink (input valid, input operation, input end_select, input value,
		output ready);
endinterface

interface dss_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] data;
	logic               last;

	modport source (output valid, output status, output data, output last, input ready);
	modport sink (input valid, input status, input data, input last, output ready);
endinterface

FILE: design/dual_stack_shared_array_top.sv
// ----------------------------------------------------------------------------
// Dual stack shared array
// Two stacks in one store, low stack grows up, high stack grows down.
// ----------------------------------------------------------------------------
// One command item is taken at a time. A push or pop has a single result,
// offered in the cycle after the command is accepted. A dump offers one
// result per slot, DEPTH results from the top index down on consecutive
// cycles while the sink is ready, one read of the store's single read port
// per slot, or one underflow result when both stacks are empty. The next
// item is accepted once the last result of the current one has been taken.
module dual_stack_shared_array_top (
	input logic       clk,
	input logic       arst_n,
	dss_in_if.sink    in_item,
	dss_out_if.source res_item
);
	import dss_pkg::*;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.res_item  (res_item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	dss_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: design/dss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/dss_ctrl.sv
// ----------------------------------------------------------------------------
// Dual stack shared array sequencer
// Stack counters, shared slot address and occupancy unit, result register.
// ----------------------------------------------------------------------------
module dss_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	dss_in_if.sink                    in_item,
	dss_out_if.source                 res_item,
	output logic                      ram_we,
	output logic [dss_pkg::ADDR_W-1:0] ram_waddr,
	output logic [dss_pkg::WORD_W-1:0] ram_wdata,
	output logic                      ram_re,
	output logic [dss_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [dss_pkg::WORD_W-1:0] ram_rdata
);
	import dss_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RESULT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    low_count_q;
	logic [CNT_W-1:0]    high_count_q;
	logic [ADDR_W-1:0]   slot_q;
	logic                dump_q;
	logic                ram_data_q;
	logic                last_q;
	status_t             status_q;

	logic                accept;
	logic                taken;
	logic [CNT_W:0]      sum;
	logic                full;
	logic                both_empty;
	logic                dump_step;
	logic [ADDR_W-1:0]   slot_next;

	function automatic logic slot_used(input logic [ADDR_W-1:0] s,
		input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi);
		logic [CNT_W-1:0] se;
		se = CNT_W'(s);
		return (se < lo) || (se >= CNT_W'(DEPTH) - hi);
	endfunction

	always_comb begin
		accept     = in_item.valid && in_item.ready;
		taken      = res_item.valid && res_item.ready;
		sum        = {1'b0, low_count_q} + {1'b0, high_count_q};
		full       = sum >= (CNT_W + 1)'(DEPTH);
		both_empty = (low_count_q == '0) && (high_count_q == '0);
		dump_step  = (state_q == S_RESULT) && taken && dump_q && (slot_q != '0);
		slot_next  = slot_q - 1'b1;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = '0;
		ram_raddr  = slot_next;
		ram_wdata  = in_item.value;
		if (accept) begin
			case (in_item.operation)
				OP_PUSH: begin
					ram_we = !full;
					if (in_item.end_select == END_LOW) begin
						ram_waddr = low_count_q[ADDR_W-1:0];
					end else begin
						ram_waddr = ADDR_W'(DEPTH - 1) - high_count_q[ADDR_W-1:0];
					end
				end
				OP_POP: begin
					if (in_item.end_select == END_LOW) begin
						ram_re    = low_count_q != '0;
						ram_raddr = ADDR_W'(low_count_q - 1'b1);
					end else begin
						ram_re    = high_count_q != '0;
						ram_raddr = ADDR_W'(CNT_W'(DEPTH) - high_count_q);
					end
				end
				OP_DUMP: begin
					ram_re    = !both_empty;
					ram_raddr = ADDR_W'(DEPTH - 1);
				end
				default: begin
				end
			endcase
		end else if (dump_step) begin
			ram_re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			low_count_q  <= '0;
			high_count_q <= '0;
			slot_q       <= '0;
			dump_q       <= 1'b0;
			ram_data_q   <= 1'b0;
			last_q       <= 1'b0;
			status_q     <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_item.operation)
							OP_PUSH: begin
								dump_q     <= 1'b0;
								ram_data_q <= 1'b0;
								last_q     <= 1'b1;
								state_q    <= S_RESULT;
								status_q   <= full ? ST_OVER : ST_OK;
								if (!full && in_item.end_select == END_LOW) begin
									low_count_q <= low_count_q + 1'b1;
								end else if (!full) begin
									high_count_q <= high_count_q + 1'b1;
								end
							end
							OP_POP: begin
								dump_q  <= 1'b0;
								last_q  <= 1'b1;
								state_q <= S_RESULT;
								if (in_item.end_select == END_LOW) begin
									ram_data_q <= low_count_q != '0;
									status_q   <= (low_count_q == '0) ? ST_UNDER : ST_OK;
									if (low_count_q != '0) begin
										low_count_q <= low_count_q - 1'b1;
									end
								end else begin
									ram_data_q <= high_count_q != '0;
									status_q   <= (high_count_q == '0) ? ST_UNDER : ST_OK;
									if (high_count_q != '0) begin
										high_count_q <= high_count_q - 1'b1;
									end
								end
							end
							OP_DUMP: begin
								state_q    <= S_RESULT;
								dump_q     <= !both_empty;
								ram_data_q <= !both_empty;
								slot_q     <= ADDR_W'(DEPTH - 1);
								last_q     <= both_empty;
								if (both_empty) begin
									status_q <= ST_UNDER;
								end else begin
									status_q <= slot_used(ADDR_W'(DEPTH - 1), low_count_q,
										high_count_q) ? ST_OK : ST_FREE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RESULT: begin
					if (dump_step) begin
						slot_q   <= slot_next;
						last_q   <= slot_next == '0;
						status_q <= slot_used(slot_next, low_count_q, high_count_q) ?
							ST_OK : ST_FREE;
					end else if (taken) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_item.ready   = state_q == S_IDLE;
	assign res_item.valid  = state_q == S_RESULT;
	assign res_item.status = status_q;
	assign res_item.last   = last_q;
	assign res_item.data   = (ram_data_q && status_q == ST_OK) ? ram_rdata : '0;

	a_no_overcommit: assert property (@(posedge clk) disable iff (!arst_n)
		sum <= (CNT_W + 1)'(DEPTH))
		else $error("stacks hold more words than the store");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.operation == OP_PUSH && !full) |=> (sum == $past(sum) + 1'b1))
		else $error("accepted push did not add one word");

	a_dump_keeps_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && dump_q) |=>
		(low_count_q == $past(low_count_q) && high_count_q == $past(high_count_q)))
		else $error("counts changed during dump");

	a_dump_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_item.valid && dump_q) |-> (last_q == (slot_q == '0)))
		else $error("dump last flag not on slot zero");

	a_no_write_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |-> !ram_we)
		else $error("store written while a result is pending");

endmodule
